>>> hdl/mcs_pkg.sv
`timescale 1ns / 1ps

package mcs_pkg;

   // price and fixed-point geometry
   localparam int PRICE_BITS   = 32;
   localparam int FRAC_BITS    = 16;
   localparam int AVG_BITS     = PRICE_BITS + FRAC_BITS;     // unsigned averages
   localparam int LINE_BITS    = AVG_BITS + 1;               // signed MACD / signal line
   localparam int DIFF_BITS    = LINE_BITS + 1;              // signed x - avg

   // Q1.16 weights, 0..65536
   localparam int W_BITS       = 17;
   localparam int WEIGHT_SHIFT = 16;
   localparam logic [W_BITS-1:0] WEIGHT_MAX = W_BITS'(65536);

   // split multiply: difference taken in two halves
   localparam int LO_BITS   = (DIFF_BITS + 1) / 2;
   localparam int HI_BITS   = DIFF_BITS - LO_BITS;
   localparam int MUL_BITS  = (W_BITS + 1) + (LO_BITS + 1);
   localparam int PROD_BITS = DIFF_BITS + W_BITS;

   localparam int BAR_BITS  = 16;

   // configuration port
   localparam int DATA_BITS = 32;
   localparam int ADDR_BITS = 4;

   localparam logic [W_BITS-1:0]   FAST_WEIGHT_RST   = W_BITS'(10082);
   localparam logic [W_BITS-1:0]   SLOW_WEIGHT_RST   = W_BITS'(4855);
   localparam logic [W_BITS-1:0]   SIGNAL_WEIGHT_RST = W_BITS'(13107);
   localparam logic [BAR_BITS-1:0] WARMUP_BARS_RST   = BAR_BITS'(35);

   typedef enum logic [1:0] {
      REG_FAST_WEIGHT,
      REG_SLOW_WEIGHT,
      REG_SIGNAL_WEIGHT,
      REG_WARMUP_BARS
   } reg_index_type;

   typedef struct packed {
      logic [W_BITS-1:0]   fast_weight;
      logic [W_BITS-1:0]   slow_weight;
      logic [W_BITS-1:0]   signal_weight;
      logic [BAR_BITS-1:0] warmup_bars;
   } cfg_type;

   // shared arithmetic unit commands
   typedef enum logic [1:0] {
      OP_IDLE,
      OP_DIFF,
      OP_MUL_LO,
      OP_MUL_HI
   } op_type;

   // trade signal codes; side codes reuse buy/sell values
   localparam logic [1:0] SIG_HOLD = 2'd0;
   localparam logic [1:0] SIG_BUY  = 2'd1;
   localparam logic [1:0] SIG_SELL = 2'd2;

endpackage

>>> hdl/mcs_csr.sv
`timescale 1ns / 1ps

module mcs_csr import mcs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready,
   output cfg_type              cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   function automatic logic [W_BITS-1:0] clamp_weight(input logic [DATA_BITS-1:0] v);
      logic [W_BITS-1:0] w;
      begin
         w = v[W_BITS-1:0];
         clamp_weight = (w > WEIGHT_MAX) ? WEIGHT_MAX : w;
      end
   endfunction

   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_FAST_WEIGHT:   cfg_in.fast_weight   = clamp_weight(csr_pwdata);
            REG_SLOW_WEIGHT:   cfg_in.slow_weight   = clamp_weight(csr_pwdata);
            REG_SIGNAL_WEIGHT: cfg_in.signal_weight = clamp_weight(csr_pwdata);
            REG_WARMUP_BARS:   cfg_in.warmup_bars   = csr_pwdata[BAR_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_FAST_WEIGHT:   csr_prdata = {{(DATA_BITS-W_BITS){1'b0}}, cfg_ff.fast_weight};
         REG_SLOW_WEIGHT:   csr_prdata = {{(DATA_BITS-W_BITS){1'b0}}, cfg_ff.slow_weight};
         REG_SIGNAL_WEIGHT: csr_prdata = {{(DATA_BITS-W_BITS){1'b0}}, cfg_ff.signal_weight};
         REG_WARMUP_BARS:   csr_prdata = {{(DATA_BITS-BAR_BITS){1'b0}}, cfg_ff.warmup_bars};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_weight   <= FAST_WEIGHT_RST;
         cfg_ff.slow_weight   <= SLOW_WEIGHT_RST;
         cfg_ff.signal_weight <= SIGNAL_WEIGHT_RST;
         cfg_ff.warmup_bars   <= WARMUP_BARS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hdl/mcs_ema_unit.sv
`timescale 1ns / 1ps

// Shared EMA datapath: d = x - avg, acc = w * d in two partial products,
// sum = avg + (acc >>> 16).
module mcs_ema_unit import mcs_pkg::*; (
   input  logic                        clock,
   input  op_type                      op,
   input  logic signed [DIFF_BITS-1:0] avg_op,
   input  logic signed [DIFF_BITS-1:0] x_op,
   input  logic        [W_BITS-1:0]    weight,
   output logic signed [DIFF_BITS-1:0] diff,
   output logic signed [DIFF_BITS-1:0] sum
);

   logic signed [DIFF_BITS-1:0] d_ff, d_in;
   logic signed [PROD_BITS-1:0] acc_ff, acc_in;

   logic        [LO_BITS-1:0]   d_lo;
   logic signed [HI_BITS-1:0]   d_hi;
   logic signed [W_BITS:0]      mul_a;
   logic signed [LO_BITS:0]     mul_b;
   logic signed [MUL_BITS-1:0]  mult;
   logic signed [PROD_BITS-1:0] mult_ext;
   logic signed [PROD_BITS-1:0] scaled;

   assign d_lo  = d_ff[LO_BITS-1:0];
   assign d_hi  = d_ff[DIFF_BITS-1:LO_BITS];
   assign mul_a = {1'b0, weight};
   assign mul_b = (op == OP_MUL_HI) ? (LO_BITS+1)'(d_hi) : {1'b0, d_lo};

   // the one multiplier, 18 x (LO_BITS+1)
   assign mult     = mul_a * mul_b;
   assign mult_ext = PROD_BITS'(mult);

   always_comb begin
      d_in   = d_ff;
      acc_in = acc_ff;
      case (op)
         OP_DIFF:   d_in   = x_op - avg_op;
         OP_MUL_LO: acc_in = mult_ext;
         OP_MUL_HI: acc_in = acc_ff + (mult_ext <<< LO_BITS);
         default: begin
            d_in   = d_ff;
            acc_in = acc_ff;
         end
      endcase
   end

   // floor shift; true step lies between 0 and d, so the floored step stays in that range
   assign scaled = acc_ff >>> WEIGHT_SHIFT;
   assign sum    = avg_op + scaled[DIFF_BITS-1:0];
   assign diff   = d_ff;

   always_ff @(posedge clock) begin
      d_ff   <= d_in;
      acc_ff <= acc_in;
   end

endmodule

>>> hdl/macd_crossover_signal.sv
`timescale 1ns / 1ps

// Channel   Direction  Transfer when             Payload
// req       in         req_valid & req_ready     req_close_price
// rsp       out        rsp_valid & rsp_ready     rsp_trade_signal, rsp_macd_value,
//                                                rsp_signal_line_value, rsp_warmed_up
// csr       in         psel&penable&pwrite       APB registers at 0x0, 0x4, 0x8, 0xC
//
// First bar: seeds the averages only and goes straight to the decision step.
// Later bars: three EMA updates of 4 steps each through the one shared
// multiplier unit, plus MACD difference, copy and decision steps, plus idle.
// Reset (synchronous, active high) clears averages, bar count and side, and
// restores register defaults.
// req_ready is high only while idle; a finished result waits in the output
// register and the next bar may start while rsp is stalled. A bar that
// finishes while the previous result still waits holds in the decision step.
module macd_crossover_signal import mcs_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic        [PRICE_BITS-1:0] req_close_price,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic        [1:0]           rsp_trade_signal,
   output logic signed [LINE_BITS-1:0] rsp_macd_value,
   output logic signed [LINE_BITS-1:0] rsp_signal_line_value,
   output logic                        rsp_warmed_up,
   // configuration
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic        [ADDR_BITS-1:0] csr_paddr,
   input  logic        [DATA_BITS-1:0] csr_pwdata,
   output logic        [DATA_BITS-1:0] csr_prdata,
   output logic                        csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_MACD,
      ST_LINE,
      ST_DONE
   } state_type;

   // which average the shared unit is working on
   typedef enum logic [1:0] {
      LANE_FAST,
      LANE_SLOW,
      LANE_MACD,
      LANE_SIGNAL
   } lane_type;

   cfg_type cfg;

   state_type state_ff, state_in;
   lane_type  lane_ff, lane_in;

   logic        [AVG_BITS-1:0]  x_ff, x_in;
   logic        [AVG_BITS-1:0]  fast_ff, fast_in;
   logic        [AVG_BITS-1:0]  slow_ff, slow_in;
   logic signed [LINE_BITS-1:0] macd_ff, macd_in;
   logic signed [LINE_BITS-1:0] signal_ff, signal_in;
   logic        [BAR_BITS-1:0]  count_ff, count_in;
   logic        [1:0]           side_ff, side_in;     // SIG_HOLD means no side yet

   logic                        out_valid_ff, out_valid_in;
   logic        [1:0]           out_sig_ff, out_sig_in;
   logic signed [LINE_BITS-1:0] out_macd_ff, out_macd_in;
   logic signed [LINE_BITS-1:0] out_line_ff, out_line_in;
   logic                        out_warm_ff, out_warm_in;

   op_type                      op;
   logic signed [DIFF_BITS-1:0] avg_op, x_op, diff, sum;
   logic        [W_BITS-1:0]    weight;

   logic                        accept;
   logic                        out_free;
   logic                        warm;
   logic        [1:0]           side_now;

   mcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mcs_ema_unit u_ema (
      .clock  (clock),
      .op     (op),
      .avg_op (avg_op),
      .x_op   (x_op),
      .weight (weight),
      .diff   (diff),
      .sum    (sum)
   );

   // operand select for the shared unit
   always_comb begin
      case (lane_ff)
         LANE_FAST: begin
            avg_op = {{(DIFF_BITS-AVG_BITS){1'b0}}, fast_ff};
            x_op   = {{(DIFF_BITS-AVG_BITS){1'b0}}, x_ff};
            weight = cfg.fast_weight;
         end
         LANE_SLOW: begin
            avg_op = {{(DIFF_BITS-AVG_BITS){1'b0}}, slow_ff};
            x_op   = {{(DIFF_BITS-AVG_BITS){1'b0}}, x_ff};
            weight = cfg.slow_weight;
         end
         LANE_MACD: begin
            // diff = fast - slow
            avg_op = {{(DIFF_BITS-AVG_BITS){1'b0}}, slow_ff};
            x_op   = {{(DIFF_BITS-AVG_BITS){1'b0}}, fast_ff};
            weight = cfg.signal_weight;
         end
         LANE_SIGNAL: begin
            avg_op = {signal_ff[LINE_BITS-1], signal_ff};
            x_op   = {macd_ff[LINE_BITS-1], macd_ff};
            weight = cfg.signal_weight;
         end
         default: begin
            avg_op = '0;
            x_op   = '0;
            weight = '0;
         end
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_DIFF, ST_MACD: op = OP_DIFF;
         ST_MUL_LO:        op = OP_MUL_LO;
         ST_MUL_HI:        op = OP_MUL_HI;
         default:          op = OP_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;

   // decision inputs; equal lines count as the lower side
   assign warm     = (count_ff >= cfg.warmup_bars);
   assign side_now = (macd_ff > signal_ff) ? SIG_BUY : SIG_SELL;

   always_comb begin
      state_in     = state_ff;
      lane_in      = lane_ff;
      x_in         = x_ff;
      fast_in      = fast_ff;
      slow_in      = slow_ff;
      macd_in      = macd_ff;
      signal_in    = signal_ff;
      count_in     = count_ff;
      side_in      = side_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_sig_in   = out_sig_ff;
      out_macd_in  = out_macd_ff;
      out_line_in  = out_line_ff;
      out_warm_in  = out_warm_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in     = {req_close_price, {FRAC_BITS{1'b0}}};
               count_in = (count_ff == '1) ? count_ff : count_ff + 1'b1;
               lane_in  = LANE_FAST;
               if (count_ff == '0) begin
                  // first bar seeds both averages exactly
                  fast_in   = {req_close_price, {FRAC_BITS{1'b0}}};
                  slow_in   = {req_close_price, {FRAC_BITS{1'b0}}};
                  macd_in   = '0;
                  signal_in = '0;
                  state_in  = ST_DONE;
               end else begin
                  state_in  = ST_DIFF;
               end
            end
         end
         ST_DIFF:   state_in = ST_MUL_LO;
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_SUM;
         ST_SUM: begin
            case (lane_ff)
               LANE_FAST: begin
                  fast_in  = sum[AVG_BITS-1:0];
                  lane_in  = LANE_SLOW;
                  state_in = ST_DIFF;
               end
               LANE_SLOW: begin
                  slow_in  = sum[AVG_BITS-1:0];
                  lane_in  = LANE_MACD;
                  state_in = ST_MACD;
               end
               default: begin
                  signal_in = sum[LINE_BITS-1:0];
                  state_in  = ST_DONE;
               end
            endcase
         end
         ST_MACD: state_in = ST_LINE;
         ST_LINE: begin
            macd_in  = diff[LINE_BITS-1:0];
            lane_in  = LANE_SIGNAL;
            state_in = ST_DIFF;
         end
         ST_DONE: begin
            // wait here until the output register is free
            if (out_free) begin
               out_valid_in = 1'b1;
               out_macd_in  = macd_ff;
               out_line_in  = signal_ff;
               out_warm_in  = warm;
               out_sig_in   = SIG_HOLD;
               if (warm) begin
                  if (side_ff != SIG_HOLD && side_now != side_ff) begin
                     out_sig_in = side_now;
                  end
                  side_in = side_now;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lane_ff      <= LANE_FAST;
         fast_ff      <= '0;
         slow_ff      <= '0;
         macd_ff      <= '0;
         signal_ff    <= '0;
         count_ff     <= '0;
         side_ff      <= SIG_HOLD;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lane_ff      <= lane_in;
         fast_ff      <= fast_in;
         slow_ff      <= slow_in;
         macd_ff      <= macd_in;
         signal_ff    <= signal_in;
         count_ff     <= count_in;
         side_ff      <= side_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input price and result payload
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      out_sig_ff  <= out_sig_in;
      out_macd_ff <= out_macd_in;
      out_line_ff <= out_line_in;
      out_warm_ff <= out_warm_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_trade_signal      = out_sig_ff;
   assign rsp_macd_value        = out_macd_ff;
   assign rsp_signal_line_value = out_line_ff;
   assign rsp_warmed_up         = out_warm_ff;

endmodule
